### rtl/bfcc_pkg.sv
// ----------------------------------------------------------------------------
// bfcc_pkg
// Shared types and constants of the tree frustum culler.
// ----------------------------------------------------------------------------
package bfcc_pkg;

  localparam int COORD_BITS = 20;
  localparam int VEC_W      = 3 * COORD_BITS;
  localparam int MAX_NODES  = 1024;
  localparam int MAX_REFS   = 4096;
  localparam int MAX_CHUNKS = 1024;
  localparam int NODE_AW    = 10;
  localparam int REF_AW     = 12;
  localparam int CHUNK_AW   = 10;
  localparam int NRM_W      = 2 * COORD_BITS + 2;

  typedef enum logic [1:0] {
    OP_NODE  = 2'd0,
    OP_REF   = 2'd1,
    OP_QUERY = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_POSITION    = 3'd0,
    REG_FORWARD     = 3'd1,
    REG_RIGHT       = 3'd2,
    REG_UP          = 3'd3,
    REG_FOCAL       = 3'd4,
    REG_ASPECT      = 3'd5,
    REG_NEAR        = 3'd6,
    REG_CHUNK_TOTAL = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [11:0]      slot;
    logic [VEC_W-1:0] box_min;
    logic [VEC_W-1:0] box_max;
    logic [9:0]       left_node;
    logic [9:0]       right_node;
    logic             is_leaf;
    logic [11:0]      first_reference;
    logic [12:0]      reference_count;
    logic [9:0]       chunk_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        camera_fallback;
    logic [10:0] visible_total;
    logic [10:0] nodes_tested;
    logic        visible_flag;
  } out_item_t;

  typedef struct packed {
    logic [VEC_W-1:0]   position;
    logic [VEC_W-1:0]   forward;
    logic [VEC_W-1:0]   right;
    logic [VEC_W-1:0]   up;
    logic signed [19:0] focal_length;
    logic signed [19:0] aspect_ratio;
    logic signed [19:0] near_distance;
    logic [10:0]        chunk_total;
  } cfg_t;

  typedef struct packed {
    in_item_t item;
    logic     bad;
    logic     empty;
  } cmd_t;

  typedef struct packed {
    logic [VEC_W-1:0] box_min;
    logic [VEC_W-1:0] box_max;
    logic [9:0]       left_node;
    logic [9:0]       right_node;
    logic             is_leaf;
    logic [11:0]      first_reference;
    logic [12:0]      reference_count;
  } node_rec_t;

  function automatic logic signed [COORD_BITS-1:0] coord(input logic [VEC_W-1:0] v,
                                                          input logic [1:0] axis);
    logic signed [COORD_BITS-1:0] c;
    case (axis)
      2'd0:    c = v[0 +: COORD_BITS];
      2'd1:    c = v[COORD_BITS +: COORD_BITS];
      default: c = v[2*COORD_BITS +: COORD_BITS];
    endcase
    return c;
  endfunction

endpackage

### rtl/bfcc_front.sv
// ----------------------------------------------------------------------------
// bfcc_front
// Accepts command transactions and classifies them for the back end.
// ----------------------------------------------------------------------------
module bfcc_front import bfcc_pkg::*; (
  input  logic     start,
  input  logic     full,
  input  in_item_t request,
  output logic     push,
  output cmd_t     cmd
);

  always_comb begin
    push       = start && !full;
    cmd.item   = request;
    cmd.empty  = (request.slot == 12'd0);
    unique case (op_e'(request.opcode))
      OP_NODE:  cmd.bad = (request.slot >= 12'(MAX_NODES));
      OP_REF:   cmd.bad = ({1'b0, request.slot} >= 13'(MAX_REFS));
      OP_QUERY: cmd.bad = (request.slot > 12'(MAX_NODES));
      OP_READ:  cmd.bad = (request.slot >= 12'(MAX_CHUNKS));
      default:  cmd.bad = 1'b0;
    endcase
  end

endmodule

### rtl/bfcc_queue.sv
// ----------------------------------------------------------------------------
// bfcc_queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module bfcc_queue import bfcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd,
  input  logic take,
  output logic full,
  output logic avail,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(take);
    end
  end

endmodule

### rtl/bfcc_back.sv
// ----------------------------------------------------------------------------
// bfcc_back
// Executes commands: table writes, flag reads and the culling tree walk.
// ----------------------------------------------------------------------------
module bfcc_back import bfcc_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      avail,
  input  cmd_t      head,
  output logic      take,
  output logic      done,
  output out_item_t result
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLEAR  = 13'b0000000000010,
    S_WRITE  = 13'b0000000000100,
    S_READ   = 13'b0000000001000,
    S_SETUP  = 13'b0000000010000,
    S_FILL   = 13'b0000000100000,
    S_POP    = 13'b0000001000000,
    S_FETCH  = 13'b0000010000000,
    S_CLASS  = 13'b0000100000000,
    S_PUSH   = 13'b0001000000000,
    S_REF    = 13'b0010000000000,
    S_REFCHK = 13'b0100000000000,
    S_VIS    = 13'b1000000000000
  } state_t;

  state_t state;
  cmd_t   cur;
  logic   boot;
  logic [CHUNK_AW:0] sweep;
  logic [10:0] ct;
  logic [11:0] nodes;
  logic [SP_W-1:0] sp;
  logic [10:0] tested;
  logic [10:0] visible;
  logic bad;
  logic fallback;
  logic [2:0] grp;
  logic [2:0] plane;
  logic [1:0] axis;
  logic corner;
  logic cut;
  logic cam_bad;
  logic push_phase;
  logic [12:0] k;
  logic [CHUNK_AW-1:0] chunk;
  logic signed [41:0] sq_sum;
  logic signed [39:0] fr [3];
  logic signed [39:0] aw [3];
  logic signed [39:0] fu [3];
  logic signed [NRM_W-1:0] nrm [5][3];
  logic signed [63:0] acc;

  node_rec_t           node_mem [MAX_NODES];
  node_rec_t           node_q;
  logic [9:0]          ref_mem [MAX_REFS];
  logic [9:0]          ref_q;
  logic                vis_mem [MAX_CHUNKS];
  logic                vis_q;
  logic [9:0]          stack_mem [STACK_DEPTH];
  logic [9:0]          stack_q;

  logic                node_we;
  logic [NODE_AW-1:0]  node_ra;
  logic                ref_we;
  logic [REF_AW-1:0]   ref_ra;
  logic                vis_we;
  logic                vis_wd;
  logic [CHUNK_AW-1:0] vis_wa;
  logic [CHUNK_AW-1:0] vis_ra;
  logic                stack_we;
  logic [SA_W-1:0]     stack_wa;
  logic [9:0]          stack_wd;
  logic [SP_W-1:0]     sp_m1;

  logic signed [19:0]       mul_a;
  logic signed [19:0]       mul_b;
  logic signed [39:0]       sprod;
  logic signed [41:0]       sq_next;
  logic signed [COORD_BITS-1:0] cam_c;
  logic signed [COORD_BITS-1:0] box_c;
  logic signed [COORD_BITS:0]   rel;
  logic signed [NRM_W-1:0]  nsel;
  logic signed [62:0]       cprod;
  logic signed [63:0]       offset;
  logic signed [63:0]       csum;
  logic                     cut_next;
  logic [13:0]              pos;
  logic                     cam_invalid;
  logic                     no_room;

  function automatic out_item_t make_result(input logic [1:0] st, input logic fb,
                                            input logic [10:0] vt, input logic [10:0] nt,
                                            input logic fl);
    out_item_t r;
    r.status          = st;
    r.camera_fallback = fb;
    r.visible_total   = vt;
    r.nodes_tested    = nt;
    r.visible_flag    = fl;
    return r;
  endfunction

  assign sp_m1 = sp - SP_W'(1);
  assign take  = (state == S_IDLE) && avail;

  always_comb begin
    unique case (grp)
      3'd0:    begin mul_a = coord(cfg.forward, axis); mul_b = coord(cfg.forward, axis); end
      3'd1:    begin mul_a = coord(cfg.right, axis);   mul_b = coord(cfg.right, axis);   end
      3'd2:    begin mul_a = coord(cfg.up, axis);      mul_b = coord(cfg.up, axis);      end
      3'd3:    begin mul_a = cfg.focal_length;         mul_b = coord(cfg.right, axis);   end
      3'd4:    begin mul_a = cfg.aspect_ratio;         mul_b = coord(cfg.forward, axis); end
      default: begin mul_a = cfg.focal_length;         mul_b = coord(cfg.up, axis);      end
    endcase
    sprod   = mul_a * mul_b;
    sq_next = sq_sum + 42'(sprod);
    cam_invalid = cam_bad || (cfg.focal_length <= 20'sd0) ||
                  (cfg.aspect_ratio <= 20'sd0) || (cfg.near_distance < 20'sd0);

    nsel   = nrm[plane][axis];
    cam_c  = coord(cfg.position, axis);
    box_c  = ((nsel >= 0) ^ corner) ? coord(node_q.box_max, axis)
                                    : coord(node_q.box_min, axis);
    rel    = 21'(box_c) - 21'(cam_c);
    cprod  = nsel * rel;
    offset = (plane == 3'd0 && axis == 2'd2) ?
             -(64'(cfg.near_distance) <<< 10) : 64'sd0;
    csum   = acc + 64'(cprod) + offset;
    cut_next = cut || (corner && axis == 2'd2 && csum < 0);
    no_room  = ({1'b0, sp} + (SP_W+1)'(2)) > (SP_W+1)'(STACK_DEPTH);
    pos      = {2'b00, node_q.first_reference} + {1'b0, k};
  end

  always_comb begin
    node_we  = (state == S_WRITE) && (op_e'(cur.item.opcode) == OP_NODE) && !cur.bad;
    ref_we   = (state == S_WRITE) && (op_e'(cur.item.opcode) == OP_REF) && !cur.bad;
    node_ra  = stack_q[NODE_AW-1:0];
    ref_ra   = pos[REF_AW-1:0];
    vis_we   = 1'b0;
    vis_wd   = 1'b0;
    vis_wa   = sweep[CHUNK_AW-1:0];
    vis_ra   = (state == S_REFCHK) ? ref_q : head.item.slot[CHUNK_AW-1:0];
    stack_we = 1'b0;
    stack_wa = sp[SA_W-1:0];
    stack_wd = push_phase ? node_q.left_node : node_q.right_node;
    unique case (state)
      S_CLEAR: vis_we = 1'b1;
      S_FILL: begin
        vis_we = ({1'b0, sweep} < {1'b0, ct});
        vis_wd = 1'b1;
      end
      S_VIS: begin
        vis_we = !vis_q;
        vis_wd = 1'b1;
        vis_wa = chunk;
      end
      S_SETUP: begin
        stack_we = (grp == 3'd6) && !cam_invalid;
        stack_wa = '0;
        stack_wd = '0;
      end
      S_PUSH: stack_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[cur.item.slot[NODE_AW-1:0]] <= '{cur.item.box_min, cur.item.box_max,
        cur.item.left_node, cur.item.right_node, cur.item.is_leaf,
        cur.item.first_reference, cur.item.reference_count};
    end
    if (state == S_FETCH) begin
      node_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[cur.item.slot[REF_AW-1:0]] <= cur.item.chunk_value;
    end
    ref_q <= ref_mem[ref_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    stack_q <= stack_mem[sp_m1[SA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      boot     <= 1'b1;
      sweep    <= '0;
      done     <= 1'b0;
      sp       <= '0;
      tested   <= '0;
      visible  <= '0;
      ct       <= '0;
      nodes    <= '0;
      bad      <= 1'b0;
      fallback <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            cur <= head;
            unique case (op_e'(head.item.opcode))
              OP_QUERY: begin
                state    <= S_CLEAR;
                sweep    <= '0;
                visible  <= '0;
                tested   <= '0;
                bad      <= 1'b0;
                fallback <= 1'b0;
                nodes    <= head.item.slot;
                ct       <= (cfg.chunk_total > 11'(MAX_CHUNKS)) ? 11'(MAX_CHUNKS)
                                                                : cfg.chunk_total;
              end
              OP_READ: state <= S_READ;
              default: state <= S_WRITE;
            endcase
          end
        end
        S_WRITE: begin
          done   <= 1'b1;
          result <= make_result(cur.bad ? ST_RANGE : ST_OK, 1'b0, visible, tested, 1'b0);
          state  <= S_IDLE;
        end
        S_READ: begin
          done   <= 1'b1;
          result <= make_result(cur.bad ? ST_RANGE : ST_OK, 1'b0, visible, tested,
                                !cur.bad && vis_q);
          state  <= S_IDLE;
        end
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (CHUNK_AW+1)'(MAX_CHUNKS - 1)) begin
            sweep <= '0;
            if (boot) begin
              boot  <= 1'b0;
              state <= S_IDLE;
            end else if (cur.bad || cur.empty) begin
              done   <= 1'b1;
              result <= make_result(cur.bad ? ST_RANGE : ST_OK, 1'b0, visible, tested, 1'b0);
              state  <= S_IDLE;
            end else begin
              state   <= S_SETUP;
              grp     <= 3'd0;
              axis    <= 2'd0;
              sq_sum  <= '0;
              cam_bad <= 1'b0;
            end
          end
        end
        S_SETUP: begin
          if (grp == 3'd6) begin
            if (cam_invalid) begin
              fallback <= 1'b1;
              visible  <= ct;
              state    <= S_FILL;
            end else begin
              for (int a = 0; a < 3; a++) begin
                nrm[0][a] <= NRM_W'(coord(cfg.forward, 2'(a)));
                nrm[1][a] <= NRM_W'(fr[a]) + NRM_W'(aw[a]);
                nrm[2][a] <= NRM_W'(aw[a]) - NRM_W'(fr[a]);
                nrm[3][a] <= NRM_W'(fu[a]) + (NRM_W'(coord(cfg.forward, 2'(a))) <<< 10);
                nrm[4][a] <= (NRM_W'(coord(cfg.forward, 2'(a))) <<< 10) - NRM_W'(fu[a]);
              end
              sp    <= SP_W'(1);
              state <= S_POP;
            end
          end else begin
            unique case (grp)
              3'd0, 3'd1, 3'd2: begin
                if (axis == 2'd2) begin
                  sq_sum <= '0;
                  if (sq_next < 42'sd2) begin
                    cam_bad <= 1'b1;
                  end
                end else begin
                  sq_sum <= sq_next;
                end
              end
              3'd3:    fr[axis] <= sprod;
              3'd4:    aw[axis] <= sprod;
              default: fu[axis] <= sprod;
            endcase
            if (axis == 2'd2) begin
              axis <= 2'd0;
              grp  <= grp + 3'd1;
            end else begin
              axis <= axis + 2'd1;
            end
          end
        end
        S_FILL: begin
          if ({1'b0, sweep} >= {1'b0, ct}) begin
            done   <= 1'b1;
            result <= make_result(ST_OK, 1'b1, visible, tested, 1'b0);
            state  <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_POP: begin
          if (sp == '0) begin
            done   <= 1'b1;
            result <= make_result(bad ? ST_RANGE : ST_OK, 1'b0, visible, tested, 1'b0);
            state  <= S_IDLE;
          end else begin
            sp    <= sp_m1;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if ({2'b00, stack_q} >= nodes) begin
            bad   <= 1'b1;
            state <= S_POP;
          end else if ({1'b0, tested} >= nodes) begin
            done   <= 1'b1;
            result <= make_result(ST_RANGE, 1'b0, visible, tested, 1'b0);
            state  <= S_IDLE;
          end else begin
            tested <= tested + 11'd1;
            plane  <= 3'd0;
            axis   <= 2'd0;
            corner <= 1'b0;
            cut    <= 1'b0;
            acc    <= '0;
            state  <= S_CLASS;
          end
        end
        S_CLASS: begin
          cut <= cut_next;
          if (axis == 2'd2) begin
            acc    <= '0;
            axis   <= 2'd0;
            corner <= !corner;
            if (corner) begin
              plane <= plane + 3'd1;
            end
            if (!corner && csum < 0) begin
              state <= S_POP;
            end else if (corner && plane == 3'd4) begin
              if (cut_next && !node_q.is_leaf) begin
                if (no_room) begin
                  done   <= 1'b1;
                  result <= make_result(ST_OVERFLOW, 1'b0, visible, tested, 1'b0);
                  state  <= S_IDLE;
                end else begin
                  push_phase <= 1'b0;
                  state      <= S_PUSH;
                end
              end else begin
                k     <= '0;
                state <= S_REF;
              end
            end
          end else begin
            acc  <= csum;
            axis <= axis + 2'd1;
          end
        end
        S_PUSH: begin
          sp         <= sp + SP_W'(1);
          push_phase <= 1'b1;
          if (push_phase) begin
            state <= S_POP;
          end
        end
        S_REF: begin
          if (k >= node_q.reference_count) begin
            state <= S_POP;
          end else begin
            k <= k + 13'd1;
            if (pos >= 14'(MAX_REFS)) begin
              bad <= 1'b1;
            end else begin
              state <= S_REFCHK;
            end
          end
        end
        S_REFCHK: begin
          chunk <= ref_q;
          if ({1'b0, ref_q} >= ct) begin
            bad   <= 1'b1;
            state <= S_REF;
          end else begin
            state <= S_VIS;
          end
        end
        S_VIS: begin
          if (!vis_q) begin
            visible <= visible + 11'd1;
          end
          state <= S_REF;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("Walk state is not one-hot.");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("Result strobe while the back end is still working.");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("Walk stack pointer beyond its depth.");
  a_tested_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, tested} <= nodes)
    else $error("More nodes tested than loaded.");
  a_visible_bound: assert property (@(posedge clk) disable iff (rst) visible <= ct)
    else $error("Visible count exceeds the chunk total.");

endmodule

### rtl/bvh_frustum_chunk_culler_unit.sv
// ----------------------------------------------------------------------------
// bvh_frustum_chunk_culler_unit
// Culls a stored bounding-volume tree against a five-plane camera frustum.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. Each
// command gives exactly one result, shown on result for one cycle while done
// is high; the receiver cannot stall it. Commands pass through a two-entry
// queue, so busy rises only when that queue is full.
// Node and reference writes give their result from the write state once
// they leave the queue, and flag reads from the read state. A query first
// sweeps the visible flags clear, then derives the planes, and then walks
// the tree: each tested node is classed against the planes, its children
// are pushed when it is cut and not a leaf, and each chunk reference of an
// accepted node is checked. An invalid camera marks the chunks visible.
// Configuration is written through cfg_we, cfg_index and cfg_data and must
// only change while no command is in flight.
// After reset the block sweeps the visible flags clear; commands queue up
// meanwhile and run afterwards.
module bvh_frustum_chunk_culler_unit import bfcc_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   request,
  output logic       done,
  output out_item_t  result,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [VEC_W-1:0] cfg_data
);

  cfg_t cfg;
  logic push;
  cmd_t cmd;
  logic full;
  logic avail;
  cmd_t head;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position      <= '0;
      cfg.forward       <= '0;
      cfg.right         <= '0;
      cfg.up            <= '0;
      cfg.focal_length  <= 20'sd1024;
      cfg.aspect_ratio  <= 20'sd1024;
      cfg.near_distance <= 20'sd0;
      cfg.chunk_total   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_index))
        REG_POSITION:    cfg.position      <= cfg_data;
        REG_FORWARD:     cfg.forward       <= cfg_data;
        REG_RIGHT:       cfg.right         <= cfg_data;
        REG_UP:          cfg.up            <= cfg_data;
        REG_FOCAL:       cfg.focal_length  <= cfg_data[19:0];
        REG_ASPECT:      cfg.aspect_ratio  <= cfg_data[19:0];
        REG_NEAR:        cfg.near_distance <= cfg_data[19:0];
        REG_CHUNK_TOTAL: cfg.chunk_total   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign busy = full;

  bfcc_front u_front (
    .start   (start),
    .full    (full),
    .request (request),
    .push    (push),
    .cmd     (cmd)
  );

  bfcc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .cmd   (cmd),
    .take  (take),
    .full  (full),
    .avail (avail),
    .head  (head)
  );

  bfcc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .avail  (avail),
    .head   (head),
    .take   (take),
    .done   (done),
    .result (result)
  );

endmodule

### tb/bvh_frustum_chunk_culler_checker.sv
// ----------------------------------------------------------------------------
// bvh_frustum_chunk_culler_checker
// Watches the command, result and register write ports of the culler. It
// keeps its own copy of the tree, the reference table, the visible flags and
// the camera registers, predicts one result for every accepted transaction
// and compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bvh_frustum_chunk_culler_checker import bfcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         request,
  input  logic             done,
  input  out_item_t        result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [VEC_W-1:0] cfg_data,
  output int               fails,
  output int               pending
);

  localparam int STACK_SLOTS = 64;

  logic [VEC_W-1:0] cam_pos, cam_fwd, cam_right, cam_up;
  longint           focal, aspect, near_dist;
  int               chunk_cnt;

  logic [VEC_W-1:0] node_lo [MAX_NODES];
  logic [VEC_W-1:0] node_hi [MAX_NODES];
  logic [9:0]       node_left [MAX_NODES];
  logic [9:0]       node_right [MAX_NODES];
  bit               node_leaf [MAX_NODES];
  logic [11:0]      node_first [MAX_NODES];
  logic [12:0]      node_len [MAX_NODES];
  logic [9:0]       chunk_of_ref [MAX_REFS];
  bit               seen [MAX_CHUNKS];
  int               seen_total, tested_total;

  longint           plane_n [5][3];
  longint           plane_off [5];
  longint           eye [3];

  out_item_t        expected_results[$];

  function automatic longint axis_val(logic [VEC_W-1:0] v, int a);
    logic signed [COORD_BITS-1:0] c;
    c = v[a*COORD_BITS +: COORD_BITS];
    return longint'(c);
  endfunction

  function automatic bit dir_valid(logic [VEC_W-1:0] v);
    longint s;
    s = 0;
    for (int a = 0; a < 3; a++) s += axis_val(v, a) * axis_val(v, a);
    return s >= 2;
  endfunction

  // 0 outside, 1 intersecting, 2 inside
  function automatic int box_class(logic [VEC_W-1:0] lo, logic [VEC_W-1:0] hi);
    bit     cut;
    longint dp, dq;
    cut = 0;
    for (int k = 0; k < 5; k++) begin
      dp = plane_off[k];
      dq = plane_off[k];
      for (int a = 0; a < 3; a++) begin
        if (plane_n[k][a] >= 0) begin
          dp += plane_n[k][a] * (axis_val(hi, a) - eye[a]);
          dq += plane_n[k][a] * (axis_val(lo, a) - eye[a]);
        end else begin
          dp += plane_n[k][a] * (axis_val(lo, a) - eye[a]);
          dq += plane_n[k][a] * (axis_val(hi, a) - eye[a]);
        end
      end
      if (dp < 0) return 0;
      if (dq < 0) cut = 1;
    end
    return cut ? 1 : 2;
  endfunction

  function automatic status_e cull_tree(int nodes, output bit fallback);
    int     ct, sp, idx, pos, c;
    int     stk [STACK_SLOTS];
    bit     bad;
    longint w [3], r [3], u [3];
    ct = chunk_cnt > MAX_CHUNKS ? MAX_CHUNKS : chunk_cnt;
    bad = 0;
    fallback = 0;
    foreach (seen[i]) seen[i] = 0;
    seen_total = 0;
    tested_total = 0;
    if (nodes > MAX_NODES) return ST_RANGE;
    if (nodes == 0) return ST_OK;
    if (!dir_valid(cam_fwd) || !dir_valid(cam_right) || !dir_valid(cam_up) ||
        focal <= 0 || aspect <= 0 || near_dist < 0) begin
      for (int i = 0; i < ct; i++) seen[i] = 1;
      seen_total = ct;
      fallback = 1;
      return ST_OK;
    end
    for (int a = 0; a < 3; a++) begin
      eye[a] = axis_val(cam_pos, a);
      w[a] = axis_val(cam_fwd, a);
      r[a] = axis_val(cam_right, a);
      u[a] = axis_val(cam_up, a);
      plane_n[0][a] = w[a];
      plane_n[1][a] = focal * r[a] + aspect * w[a];
      plane_n[2][a] = aspect * w[a] - focal * r[a];
      plane_n[3][a] = focal * u[a] + w[a] * 1024;
      plane_n[4][a] = w[a] * 1024 - focal * u[a];
    end
    plane_off[0] = -near_dist * 1024;
    for (int k = 1; k < 5; k++) plane_off[k] = 0;
    sp = 1;
    stk[0] = 0;
    while (sp > 0) begin
      sp--;
      idx = stk[sp];
      if (idx >= nodes) begin
        bad = 1;
        continue;
      end
      if (tested_total >= nodes) begin
        bad = 1;
        break;
      end
      tested_total++;
      c = box_class(node_lo[idx], node_hi[idx]);
      if (c == 0) continue;
      if (c == 1 && !node_leaf[idx]) begin
        if (sp + 2 > STACK_SLOTS) return ST_OVERFLOW;
        stk[sp] = node_right[idx];
        stk[sp+1] = node_left[idx];
        sp += 2;
        continue;
      end
      for (int k = 0; k < node_len[idx]; k++) begin
        pos = node_first[idx] + k;
        if (pos >= MAX_REFS) begin
          bad = 1;
          continue;
        end
        if (chunk_of_ref[pos] >= ct) begin
          bad = 1;
          continue;
        end
        if (!seen[chunk_of_ref[pos]]) begin
          seen[chunk_of_ref[pos]] = 1;
          seen_total++;
        end
      end
    end
    return bad ? ST_RANGE : ST_OK;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t o;
    bit        fb;
    o = '0;
    fb = 0;
    case (op_e'(it.opcode))
      OP_NODE: begin
        if (it.slot >= MAX_NODES) o.status = ST_RANGE;
        else begin
          node_lo[it.slot] = it.box_min;
          node_hi[it.slot] = it.box_max;
          node_left[it.slot] = it.left_node;
          node_right[it.slot] = it.right_node;
          node_leaf[it.slot] = it.is_leaf;
          node_first[it.slot] = it.first_reference;
          node_len[it.slot] = it.reference_count;
        end
      end
      OP_REF: chunk_of_ref[it.slot] = it.chunk_value;
      OP_QUERY: o.status = cull_tree(it.slot, fb);
      default: begin
        if (it.slot >= MAX_CHUNKS) o.status = ST_RANGE;
        else o.visible_flag = seen[it.slot];
      end
    endcase
    o.camera_fallback = fb;
    o.visible_total = seen_total[10:0];
    o.nodes_tested = tested_total[10:0];
    return o;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      cam_pos <= '0;
      cam_fwd <= '0;
      cam_right <= '0;
      cam_up <= '0;
      focal <= 1024;
      aspect <= 1024;
      near_dist <= 0;
      chunk_cnt <= 0;
      foreach (seen[i]) seen[i] = 0;
      seen_total = 0;
      tested_total = 0;
      fails = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_e'(cfg_index))
          REG_POSITION: cam_pos <= cfg_data;
          REG_FORWARD:  cam_fwd <= cfg_data;
          REG_RIGHT:    cam_right <= cfg_data;
          REG_UP:       cam_up <= cfg_data;
          REG_FOCAL:    focal <= longint'($signed(cfg_data[19:0]));
          REG_ASPECT:   aspect <= longint'($signed(cfg_data[19:0]));
          REG_NEAR:     near_dist <= longint'($signed(cfg_data[19:0]));
          default:      chunk_cnt <= int'(cfg_data[10:0]);
        endcase
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding");
          fails++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, result.status);
          check_field("camera_fallback", e.camera_fallback, result.camera_fallback);
          check_field("visible_total", e.visible_total, result.visible_total);
          check_field("nodes_tested", e.nodes_tested, result.nodes_tested);
          check_field("visible_flag", e.visible_flag, result.visible_flag);
        end
      end
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), predict_result(request));
      end
    end
    pending <= expected_results.size();
  end

endmodule

### tb/tb_bvh_frustum_chunk_culler_unit.sv
// ----------------------------------------------------------------------------
// tb_bvh_frustum_chunk_culler_unit
// Drives the culler with node and reference loads, tree queries and flag
// reads under several camera settings and sender idle rates, and reports the
// verdict of the checker once every transaction has completed.
// ----------------------------------------------------------------------------
module tb_bvh_frustum_chunk_culler_unit;
  import bfcc_pkg::*;

  localparam int IDLE_LIMIT = 4000000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  in_item_t         request;
  logic             done;
  out_item_t        result;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [VEC_W-1:0] cfg_data;
  int               fails;
  int               pending;
  int               idle_pct;
  int               quiet_cycles;
  bit               node_loaded [MAX_NODES];

  bvh_frustum_chunk_culler_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  bvh_frustum_chunk_culler_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [VEC_W-1:0] pack3(int x, int y, int z);
    logic [31:0] xv, yv, zv;
    xv = x;
    yv = y;
    zv = z;
    return {zv[19:0], yv[19:0], xv[19:0]};
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(9) == 0) return int'($urandom_range(1048575)) - 524288;
    return int'($urandom_range(8191)) - 4096;
  endfunction

  function automatic in_item_t make_item(op_e op, int slot);
    in_item_t     it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.opcode = op;
    it.slot = 12'(slot);
    return it;
  endfunction

  task automatic send(input in_item_t it);
    request <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (op_e'(it.opcode) == OP_NODE && it.slot < MAX_NODES) node_loaded[it.slot] = 1;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_camera(input cfg_t c);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      case (reg_idx_e'(i))
        REG_POSITION: cfg_data <= c.position;
        REG_FORWARD:  cfg_data <= c.forward;
        REG_RIGHT:    cfg_data <= c.right;
        REG_UP:       cfg_data <= c.up;
        REG_FOCAL:    cfg_data <= {40'b0, c.focal_length};
        REG_ASPECT:   cfg_data <= {40'b0, c.aspect_ratio};
        REG_NEAR:     cfg_data <= {40'b0, c.near_distance};
        default:      cfg_data <= {49'b0, c.chunk_total};
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t good_camera();
    cfg_t c;
    c.position = pack3(0, 0, 0);
    c.forward = pack3(0, 0, 1024);
    c.right = pack3(1024, 0, 0);
    c.up = pack3(0, 1024, 0);
    c.focal_length = 20'sd1024;
    c.aspect_ratio = 20'sd1024;
    c.near_distance = 20'sd64;
    c.chunk_total = 11'd64;
    return c;
  endfunction

  function automatic cfg_t random_camera();
    cfg_t c;
    c.position = pack3($urandom_range(1024) - 512, $urandom_range(1024) - 512,
                       $urandom_range(1024) - 512);
    c.forward = pack3($urandom_range(1024) - 512, $urandom_range(1024) - 512,
                      $urandom_range(2048));
    c.right = pack3($urandom_range(2048), $urandom_range(1024) - 512,
                    $urandom_range(1024) - 512);
    c.up = pack3($urandom_range(1024) - 512, $urandom_range(2048),
                 $urandom_range(1024) - 512);
    c.focal_length = 20'($urandom_range(4096, 1));
    c.aspect_ratio = 20'($urandom_range(4096, 1));
    c.near_distance = 20'($urandom_range(256));
    c.chunk_total = 11'($urandom_range(80, 1));
    case ($urandom_range(9))
      0: c.focal_length = 20'(-$urandom_range(524288));
      1: c.aspect_ratio = '0;
      2: c.near_distance = 20'(-$urandom_range(524288, 1));
      3: c.up = pack3($urandom_range(1), 0, 0);
      default: ;
    endcase
    return c;
  endfunction

  function automatic cfg_t extreme_camera();
    cfg_t c;
    c.position = '1;
    c.forward = pack3(0, 0, 524287);
    c.right = pack3(-524288, 0, 0);
    c.up = pack3(0, 524287, 0);
    c.focal_length = 20'sd524287;
    c.aspect_ratio = 20'sd524287;
    c.near_distance = 20'sd0;
    c.chunk_total = 11'd1024;
    return c;
  endfunction

  task automatic put_node(int slot, bit leaf, int l, int r, bit whole);
    in_item_t it;
    int       lo [3], hi [3], half;
    it = make_item(OP_NODE, slot);
    for (int a = 0; a < 3; a++) begin
      if (whole) begin
        lo[a] = -524288;
        hi[a] = 524287;
      end else if ($urandom_range(9) == 0) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        half = $urandom_range(2048);
        lo[a] = rand_coord() - half;
        hi[a] = lo[a] + 2 * half;
      end
    end
    it.box_min = pack3(lo[0], lo[1], lo[2]);
    it.box_max = pack3(hi[0], hi[1], hi[2]);
    it.left_node = 10'(l);
    it.right_node = 10'(r);
    it.is_leaf = leaf;
    case ($urandom_range(99))
      0: begin
        it.first_reference = 12'($urandom_range(4095, 4064));
        it.reference_count = 13'($urandom_range(8191, 4096));
      end
      1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
        it.first_reference = 12'($urandom_range(4095, 4064));
        it.reference_count = 13'($urandom_range(40));
      end
      default: begin
        it.first_reference = 12'($urandom_range(63));
        it.reference_count = 13'($urandom_range(64 - it.first_reference));
      end
    endcase
    send(it);
  endtask

  task automatic build_tree(int n, bit deep);
    int l, r;
    for (int i = 0; i < n; i++) begin
      if (deep) put_node(i, 1'b0, 0, 0, 1'b1);
      else begin
        if ($urandom_range(9) == 0) begin
          l = $urandom_range(n);
          r = $urandom_range(n);
        end else begin
          l = $urandom_range(n + 1, i + 1);
          r = $urandom_range(n + 1, i + 1);
        end
        put_node(i, (i > 0 && $urandom_range(99) < 40) || l >= n, l, r,
                 $urandom_range(19) == 0);
      end
    end
  endtask

  function automatic int loaded_prefix();
    for (int i = 0; i < MAX_NODES; i++) if (!node_loaded[i]) return i;
    return MAX_NODES;
  endfunction

  task automatic query(int n);
    send(make_item(OP_QUERY, n));
  endtask

  task automatic read_flags(int cnt);
    for (int i = 0; i < cnt; i++)
      send(make_item(OP_READ, $urandom_range(9) == 0 ? $urandom_range(4095, 1024)
                                                     : $urandom_range(80)));
  endtask

  task automatic put_ref(int slot, int chunk);
    in_item_t it;
    it = make_item(OP_REF, slot);
    it.chunk_value = 10'(chunk);
    send(it);
  endtask

  task automatic random_traffic(int items);
    int     n, sent;
    cfg_t   c;
    in_item_t it;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(99)) inside
        [0:34]: begin
          n = $urandom_range(30) == 0 ? 70 : $urandom_range(12, 1);
          build_tree(n, n == 70 && $urandom_range(1));
          query(n);
          read_flags($urandom_range(6));
          sent += n + 4;
        end
        [35:54]: begin
          put_ref($urandom_range(4095), $urandom_range(3) == 0 ? $urandom_range(1023)
                                                              : $urandom_range(70));
          sent++;
        end
        [55:69]: begin
          case ($urandom_range(9))
            0: query(0);
            1: query($urandom_range(4095, 1025));
            default: query($urandom_range(loaded_prefix()));
          endcase
          sent++;
        end
        [70:84]: begin
          read_flags(3);
          sent += 3;
        end
        default: begin
          if ($urandom_range(1)) begin
            it = make_item(OP_NODE, $urandom_range(4095, 1024));
            send(it);
          end else put_node($urandom_range(1023), $urandom_range(1), $urandom_range(1023),
                            $urandom_range(1023), 1'b0);
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    cfg_t cam;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cam = good_camera();
    load_camera(cam);
    for (int i = 0; i < 64; i++) put_ref(i, i);
    for (int i = 4064; i < 4096; i++) put_ref(i, $urandom_range(1023));

    send(make_item(OP_NODE, 1024));
    send(make_item(OP_NODE, 4095));
    query(0);
    query(1025);
    query(4095);
    send(make_item(OP_READ, 1024));
    send(make_item(OP_READ, 4095));
    put_node(0, 1'b0, 1, 2, 1'b1);
    put_node(1, 1'b1, 0, 0, 1'b0);
    put_node(2, 1'b1, 1023, 1023, 1'b1);
    query(3);
    send(make_item(OP_READ, 0));
    send(make_item(OP_READ, 1023));
    build_tree(70, 1'b1);
    query(70);
    cam.focal_length = '0;
    load_camera(cam);
    query(3);
    send(make_item(OP_READ, 63));
    cam = good_camera();
    cam.aspect_ratio = 20'h80000;
    cam.chunk_total = 11'd2047;
    load_camera(cam);
    query(3);
    cam = good_camera();
    cam.near_distance = -20'sd1;
    load_camera(cam);
    query(3);
    cam = good_camera();
    cam.forward = '0;
    load_camera(cam);
    query(3);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 51;
        default: idle_pct = 37;
      endcase
      case (ph)
        0: load_camera(good_camera());
        3: load_camera(extreme_camera());
        default: load_camera(random_camera());
      endcase
      random_traffic(150);
    end

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
